[sv/bvg_pkg.sv]
`timescale 1ns / 1ps

package bvg_pkg;

   // Field widths.
   localparam int ADC_W     = 12;
   localparam int SUM_W     = 16;
   localparam int CNT_W     = 4;
   localparam int RATIO_W   = 16;
   localparam int MV_W      = 14;
   localparam int FILT_W    = 18;
   localparam int FRAC_W    = 4;
   localparam int CHG_W     = 14;
   localparam int CSR_IDX_W = 2;

   localparam logic [FILT_W-1:0] FILT_MAX = '1;

   // Configuration reset values.
   localparam logic [RATIO_W-1:0] RATIO_RESET    = 16'd8192;
   localparam logic [MV_W-1:0]    CHARGE_RESET   = 14'd4250;
   localparam logic [MV_W-1:0]    SEED_RESET     = 14'd100;
   localparam int                 SAMPLES_DEFAULT = 12;

   // Register map of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIVIDER_RATIO = 2'd0,
      CSR_CHARGE_THR    = 2'd1,
      CSR_SEED_THR      = 2'd2
   } csr_index_type;

   // Serial multiplier: MUL_A_W-bit multiplicand, one multiplier bit per cycle.
   localparam int MUL_A_W   = 13;
   localparam int MUL_B_W   = 16;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   // Serial restoring divider: one quotient bit per cycle.
   localparam int DIV_N_W   = 23;
   localparam int DIV_D_W   = 13;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   // Discharge curve.
   localparam int CURVE_PTS = 8;
   localparam int CURVE_IW  = $clog2(CURVE_PTS);
   localparam int CMV_W     = 13;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   function automatic logic [CMV_W-1:0] curve_mv(input logic [CURVE_IW-1:0] idx);
      logic [CMV_W-1:0] v;
      case (idx)
         3'd0:    v = 13'd3300;
         3'd1:    v = 13'd3600;
         3'd2:    v = 13'd3700;
         3'd3:    v = 13'd3750;
         3'd4:    v = 13'd3850;
         3'd5:    v = 13'd3950;
         3'd6:    v = 13'd4050;
         default: v = 13'd4200;
      endcase
      return v;
   endfunction

   function automatic logic [CHG_W-1:0] curve_hund(input logic [CURVE_IW-1:0] idx);
      logic [CHG_W-1:0] v;
      case (idx)
         3'd0:    v = 14'd0;
         3'd1:    v = 14'd1000;
         3'd2:    v = 14'd2500;
         3'd3:    v = 14'd4000;
         3'd4:    v = 14'd6000;
         3'd5:    v = 14'd7500;
         3'd6:    v = 14'd8800;
         default: v = 14'd10000;
      endcase
      return v;
   endfunction

endpackage

[sv/bvg_accum.sv]
`timescale 1ns / 1ps

module bvg_accum #(
   parameter int SAMPLES_PER_READING = bvg_pkg::SAMPLES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic [bvg_pkg::ADC_W-1:0]   code,
   input  logic [bvg_pkg::ADC_W-1:0]   millivolts,
   input  logic                        clear,
   output logic [bvg_pkg::SUM_W-1:0]   code_sum,
   output logic [bvg_pkg::SUM_W-1:0]   mv_sum,
   output logic                        full
);

   logic [bvg_pkg::SUM_W-1:0] code_sum_ff;
   logic [bvg_pkg::SUM_W-1:0] mv_sum_ff;
   logic [bvg_pkg::CNT_W-1:0] count_ff;
   logic                      full_ff;
   logic                      last_in;

   // The group is complete when this sample brings the count up to the group size.
   assign last_in = ({1'b0, count_ff} + (bvg_pkg::CNT_W + 1)'(1))
                    >= (bvg_pkg::CNT_W + 1)'(SAMPLES_PER_READING);

   always_ff @(posedge clock) begin
      if (reset) begin
         code_sum_ff <= '0;
         mv_sum_ff   <= '0;
         count_ff    <= '0;
         full_ff     <= 1'b0;
      end else if (clear) begin
         code_sum_ff <= '0;
         mv_sum_ff   <= '0;
         count_ff    <= '0;
         full_ff     <= 1'b0;
      end else if (take) begin
         code_sum_ff <= code_sum_ff + bvg_pkg::SUM_W'(code);
         mv_sum_ff   <= mv_sum_ff + bvg_pkg::SUM_W'(millivolts);
         if (last_in) begin
            full_ff <= 1'b1;
         end else begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   assign code_sum = code_sum_ff;
   assign mv_sum   = mv_sum_ff;
   assign full     = full_ff;

endmodule

[sv/bvg_smul.sv]
`timescale 1ns / 1ps

module bvg_smul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bvg_pkg::MUL_A_W-1:0]    mcand,
   input  logic [bvg_pkg::MUL_B_W-1:0]    mplier,
   output bvg_pkg::unit_stat_type         stat,
   output logic [bvg_pkg::MUL_P_W-1:0]    product
);

   logic [bvg_pkg::MUL_A_W-1:0]   a_ff;
   logic [bvg_pkg::MUL_A_W-1:0]   hi_ff;
   logic [bvg_pkg::MUL_B_W-1:0]   lo_ff;
   logic [bvg_pkg::MUL_CNT_W-1:0] cnt_ff;
   logic                          busy_ff;
   logic                          done_ff;
   logic [bvg_pkg::MUL_A_W:0]     sum_in;

   // Shift-add: the low half holds the multiplier bits not yet used and
   // collects the low product bits as the word shifts right.
   assign sum_in = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            a_ff    <= mcand;
            hi_ff   <= '0;
            lo_ff   <= mplier;
         end else if (busy_ff) begin
            hi_ff  <= sum_in[bvg_pkg::MUL_A_W:1];
            lo_ff  <= {sum_in[0], lo_ff[bvg_pkg::MUL_B_W-1:1]};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == bvg_pkg::MUL_CNT_W'(bvg_pkg::MUL_B_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = {hi_ff, lo_ff};

endmodule

[sv/bvg_sdiv.sv]
`timescale 1ns / 1ps

module bvg_sdiv (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bvg_pkg::DIV_N_W-1:0]    dividend,
   input  logic [bvg_pkg::DIV_D_W-1:0]    divisor,
   output bvg_pkg::unit_stat_type         stat,
   output logic [bvg_pkg::DIV_N_W-1:0]    quotient
);

   logic [bvg_pkg::DIV_D_W-1:0]   dsr_ff;
   logic [bvg_pkg::DIV_D_W-1:0]   rem_ff;
   logic [bvg_pkg::DIV_N_W-1:0]   quo_ff;
   logic [bvg_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                          busy_ff;
   logic                          done_ff;
   logic [bvg_pkg::DIV_D_W:0]     trial_in;
   logic [bvg_pkg::DIV_D_W:0]     diff_in;
   logic                          fits_in;
   logic [bvg_pkg::DIV_D_W-1:0]   rem_in;

   // Restoring division: the dividend shifts out of the top of quo_ff into
   // the remainder while quotient bits shift in at the bottom.
   assign trial_in = {rem_ff, quo_ff[bvg_pkg::DIV_N_W-1]};
   assign diff_in  = trial_in - {1'b0, dsr_ff};
   assign fits_in  = trial_in >= {1'b0, dsr_ff};
   assign rem_in   = fits_in ? diff_in[bvg_pkg::DIV_D_W-1:0]
                             : trial_in[bvg_pkg::DIV_D_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            dsr_ff  <= divisor;
            rem_ff  <= '0;
            quo_ff  <= dividend;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[bvg_pkg::DIV_N_W-2:0], fits_in};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == bvg_pkg::DIV_CNT_W'(bvg_pkg::DIV_N_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

[sv/battery_voltage_gauge.sv]
`timescale 1ns / 1ps

// Channel   Direction  Word contents (lowest bit first)
// req_      in         tdata: adc_code[11:0], adc_millivolts[23:12]
// rsp_      out        tdata: raw_average[11:0], battery_mv[25:12],
//                      charge_hundredths[39:26]; tuser: is_charging
// csr_      in         csr_index selects the register, csr_data carries the value
//
// Samples are taken one per cycle while no complete group waits for the sequencer.
// Once a group is complete, req_tready stays low while the first serial
// division runs, longer if the sequencer is still busy with the previous group.
// A result follows the last sample of its group through the 23-step serial divider
// (used three times) and the 16-step multiplier (twice); when the voltage clamps at
// either end of the curve, the curve multiply and divide are skipped.
// Reset is synchronous and active high; it restores the register reset values.
// A result waiting on rsp_tready does not stop samples; only the next group end waits.

module battery_voltage_gauge #(
   parameter int SAMPLES_PER_READING = bvg_pkg::SAMPLES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,   // adc_code, adc_millivolts
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,   // raw_average, battery_mv,
                                                          // charge_hundredths
   output logic                              rsp_tuser,   // is_charging
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bvg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [15:0]                       csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_CODE,
      ST_DIV_MV,
      ST_MUL_MEAS,
      ST_FILTER,
      ST_SEG,
      ST_MUL_CURVE,
      ST_DIV_CURVE,
      ST_EMIT
   } state_type;

   // Configuration registers.
   logic [bvg_pkg::RATIO_W-1:0] ratio_ff;
   logic [bvg_pkg::MV_W-1:0]    charge_thr_ff;
   logic [bvg_pkg::MV_W-1:0]    seed_thr_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff      <= bvg_pkg::RATIO_RESET;
         charge_thr_ff <= bvg_pkg::CHARGE_RESET;
         seed_thr_ff   <= bvg_pkg::SEED_RESET;
      end else if (csr_valid) begin
         unique case (bvg_pkg::csr_index_type'(csr_index))
            bvg_pkg::CSR_DIVIDER_RATIO: ratio_ff      <= csr_data;
            bvg_pkg::CSR_CHARGE_THR:    charge_thr_ff <= csr_data[bvg_pkg::MV_W-1:0];
            bvg_pkg::CSR_SEED_THR:      seed_thr_ff   <= csr_data[bvg_pkg::MV_W-1:0];
            default: ;
         endcase
      end
   end

   // Sample accumulation.
   logic                          acc_clear_ff;
   logic                          acc_full;
   logic [bvg_pkg::SUM_W-1:0]     code_sum;
   logic [bvg_pkg::SUM_W-1:0]     mv_sum;

   assign req_tready = !acc_full;

   bvg_accum #(
      .SAMPLES_PER_READING(SAMPLES_PER_READING)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .take       (req_tvalid && req_tready),
      .code       (req_tdata[11:0]),
      .millivolts (req_tdata[23:12]),
      .clear      (acc_clear_ff),
      .code_sum   (code_sum),
      .mv_sum     (mv_sum),
      .full       (acc_full)
   );

   // Shared serial units.
   logic                           div_start_ff;
   logic [bvg_pkg::DIV_N_W-1:0]    div_dend_ff;
   logic [bvg_pkg::DIV_D_W-1:0]    div_dsr_ff;
   bvg_pkg::unit_stat_type         div_stat;
   logic [bvg_pkg::DIV_N_W-1:0]    div_quo;

   logic                           mul_start_ff;
   logic [bvg_pkg::MUL_A_W-1:0]    mul_a_ff;
   logic [bvg_pkg::MUL_B_W-1:0]    mul_b_ff;
   bvg_pkg::unit_stat_type         mul_stat;
   logic [bvg_pkg::MUL_P_W-1:0]    mul_prod;

   bvg_sdiv u_sdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dend_ff),
      .divisor  (div_dsr_ff),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   bvg_smul u_smul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .mcand   (mul_a_ff),
      .mplier  (mul_b_ff),
      .stat    (mul_stat),
      .product (mul_prod)
   );

   // Sequencer datapath.
   state_type                        state_ff;
   logic [bvg_pkg::ADC_W-1:0]        raw_avg_ff;
   logic [bvg_pkg::FILT_W-1:0]       meas_ff;
   logic [bvg_pkg::FILT_W-1:0]       filt_ff;
   logic [bvg_pkg::CHG_W-1:0]        base_ff;
   logic [bvg_pkg::CHG_W-1:0]        charge_ff;
   logic                             charging_ff;
   logic                             rsp_valid_ff;
   logic [39:0]                      rsp_data_ff;
   logic                             rsp_user_ff;

   logic [bvg_pkg::MUL_P_W-9:0]      prod_sh_in;
   logic [bvg_pkg::FILT_W-1:0]       meas_in;
   logic [bvg_pkg::FILT_W+1:0]       filt_sum_in;
   logic [bvg_pkg::FILT_W-1:0]       filt_in;
   logic                             seed_hit_in;
   logic [bvg_pkg::CURVE_IW-1:0]     seg_in;
   logic [bvg_pkg::CURVE_IW-1:0]     seg_lo_in;
   logic [bvg_pkg::FILT_W-1:0]       off_full_in;
   logic [bvg_pkg::CMV_W-1:0]        span_mv_in;
   logic [bvg_pkg::CMV_W+3:0]        span_in;
   logic [bvg_pkg::CHG_W-1:0]        rise_in;
   logic                             clamp_lo_in;
   logic                             clamp_hi_in;
   logic                             charging_in;

   // Measured voltage in Q4 mV: product of the average and the Q12 ratio, less 8 bits.
   assign prod_sh_in = mul_prod[bvg_pkg::MUL_P_W-1:8];
   assign meas_in    = (prod_sh_in > (bvg_pkg::MUL_P_W - 8)'(bvg_pkg::FILT_MAX))
                       ? bvg_pkg::FILT_MAX : prod_sh_in[bvg_pkg::FILT_W-1:0];

   assign seed_hit_in = filt_ff <= bvg_pkg::FILT_W'({seed_thr_ff, 4'b0000});
   assign filt_sum_in = (bvg_pkg::FILT_W + 2)'({filt_ff, 1'b0})
                        + (bvg_pkg::FILT_W + 2)'(filt_ff)
                        + (bvg_pkg::FILT_W + 2)'(meas_ff);
   assign filt_in     = seed_hit_in ? meas_ff : filt_sum_in[bvg_pkg::FILT_W+1:2];

   assign charging_in = filt_ff > bvg_pkg::FILT_W'({charge_thr_ff, 4'b0000});
   assign clamp_lo_in = filt_ff
                        <= bvg_pkg::FILT_W'({bvg_pkg::curve_mv(3'd0), 4'b0000});
   assign clamp_hi_in = filt_ff
                        >= bvg_pkg::FILT_W'({bvg_pkg::curve_mv(3'd7), 4'b0000});

   // The first curve point above the voltage ends the segment.
   always_comb begin
      seg_in = bvg_pkg::CURVE_IW'(bvg_pkg::CURVE_PTS - 1);
      for (int i = bvg_pkg::CURVE_PTS - 1; i >= 1; i--) begin
         if (filt_ff < bvg_pkg::FILT_W'({bvg_pkg::curve_mv(bvg_pkg::CURVE_IW'(i)),
                                         4'b0000})) begin
            seg_in = bvg_pkg::CURVE_IW'(i);
         end
      end
   end

   assign seg_lo_in   = seg_in - 1'b1;
   assign off_full_in = filt_ff
                        - bvg_pkg::FILT_W'({bvg_pkg::curve_mv(seg_lo_in), 4'b0000});
   assign span_mv_in  = bvg_pkg::curve_mv(seg_in) - bvg_pkg::curve_mv(seg_lo_in);
   assign span_in     = {span_mv_in, 4'b0000};
   assign rise_in     = bvg_pkg::curve_hund(seg_in) - bvg_pkg::curve_hund(seg_lo_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_start_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         acc_clear_ff <= 1'b0;
         filt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         acc_clear_ff <= 1'b0;
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (acc_full) begin
                  div_start_ff <= 1'b1;
                  div_dend_ff  <= bvg_pkg::DIV_N_W'(code_sum);
                  div_dsr_ff   <= bvg_pkg::DIV_D_W'(SAMPLES_PER_READING);
                  state_ff     <= ST_DIV_CODE;
               end
            end
            ST_DIV_CODE: begin
               if (div_stat.done) begin
                  raw_avg_ff   <= div_quo[bvg_pkg::ADC_W-1:0];
                  div_start_ff <= 1'b1;
                  div_dend_ff  <= bvg_pkg::DIV_N_W'(mv_sum);
                  // The divider latches the sum at the same edge that clears it.
                  acc_clear_ff <= 1'b1;
                  state_ff     <= ST_DIV_MV;
               end
            end
            ST_DIV_MV: begin
               if (div_stat.done) begin
                  mul_start_ff <= 1'b1;
                  mul_a_ff     <= bvg_pkg::MUL_A_W'(div_quo[bvg_pkg::ADC_W-1:0]);
                  mul_b_ff     <= ratio_ff;
                  state_ff     <= ST_MUL_MEAS;
               end
            end
            ST_MUL_MEAS: begin
               if (mul_stat.done) begin
                  meas_ff  <= meas_in;
                  state_ff <= ST_FILTER;
               end
            end
            ST_FILTER: begin
               filt_ff  <= filt_in;
               state_ff <= ST_SEG;
            end
            ST_SEG: begin
               charging_ff <= charging_in;
               if (clamp_lo_in) begin
                  charge_ff <= bvg_pkg::curve_hund(3'd0);
                  state_ff  <= ST_EMIT;
               end else if (clamp_hi_in) begin
                  charge_ff <= bvg_pkg::curve_hund(3'd7);
                  state_ff  <= ST_EMIT;
               end else begin
                  base_ff      <= bvg_pkg::curve_hund(seg_lo_in);
                  div_dsr_ff   <= span_in[bvg_pkg::DIV_D_W-1:0];
                  mul_start_ff <= 1'b1;
                  mul_a_ff     <= off_full_in[bvg_pkg::MUL_A_W-1:0];
                  mul_b_ff     <= bvg_pkg::MUL_B_W'(rise_in);
                  state_ff     <= ST_MUL_CURVE;
               end
            end
            ST_MUL_CURVE: begin
               if (mul_stat.done) begin
                  div_start_ff <= 1'b1;
                  div_dend_ff  <= mul_prod[bvg_pkg::DIV_N_W-1:0];
                  state_ff     <= ST_DIV_CURVE;
               end
            end
            ST_DIV_CURVE: begin
               if (div_stat.done) begin
                  charge_ff <= base_ff + div_quo[bvg_pkg::CHG_W-1:0];
                  state_ff  <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {charge_ff,
                                   filt_ff[bvg_pkg::FILT_W-1:bvg_pkg::FRAC_W],
                                   raw_avg_ff};
                  rsp_user_ff  <= charging_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTH
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> !div_stat.busy)
      else $error("divider started while busy");

   a_mul_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start_ff |-> !mul_stat.busy)
      else $error("multiplier started while busy");

   a_charge_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[39:26] <= bvg_pkg::curve_hund(3'd7))
      else $error("charge estimate above full scale");

   a_flag_matches: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> rsp_user_ff == charging_in)
      else $error("charging flag disagrees with filtered voltage");
`endif

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import bvg_pkg::*;

   localparam int GROUP_SIZE    = SAMPLES_DEFAULT;
   localparam int SETTLE_CYCLES = 200;
   localparam int STALL_LIMIT   = 6000;
   localparam int LONG_HOLD     = 700;
   localparam int KNEES         = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct {
      logic [11:0] raw_average;
      logic [13:0] battery_mv;
      logic [13:0] charge_hundredths;
      logic        is_charging;
   } reading_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [23:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [39:0]          rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0]          csr_data = '0;

   // Mirror of the gauge configuration and state.
   logic [15:0] cfg_ratio;
   logic [13:0] cfg_charge_thr;
   logic [13:0] cfg_seed_thr;
   logic [15:0] code_acc;
   logic [15:0] mv_acc;
   logic [3:0]  samples_in;
   logic [17:0] filt_q4;

   logic [23:0] pending_samples[$];
   reading_type readings_due[$];
   reading_type front_reading;

   int errors = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   int hold_left = 0;
   int hold_ask = 0;
   int hold_seen = 0;
   int quiet_cycles = 0;
   bit idling_on = 1'b1;

   battery_voltage_gauge DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned knee_mv(input int i);
      int unsigned v;
      case (i)
         0:       v = 3300;
         1:       v = 3600;
         2:       v = 3700;
         3:       v = 3750;
         4:       v = 3850;
         5:       v = 3950;
         6:       v = 4050;
         default: v = 4200;
      endcase
      return v;
   endfunction

   function automatic int unsigned knee_charge(input int i);
      int unsigned v;
      case (i)
         0:       v = 0;
         1:       v = 1000;
         2:       v = 2500;
         3:       v = 4000;
         4:       v = 6000;
         5:       v = 7500;
         6:       v = 8800;
         default: v = 10000;
      endcase
      return v;
   endfunction

   // Piecewise-linear discharge curve on the Q4 voltage, clamped at both ends.
   function automatic logic [13:0] charge_of(input logic [17:0] v_q4);
      int unsigned v, off, span, rise, result;
      bit found;
      v = v_q4;
      found = 1'b0;
      result = knee_charge(KNEES - 1);
      if (v <= knee_mv(0) * 16) begin
         result = 0;
      end else if (v < knee_mv(KNEES - 1) * 16) begin
         for (int i = 1; i < KNEES; i++) begin
            if (!found && v < knee_mv(i) * 16) begin
               off = v - knee_mv(i - 1) * 16;
               span = (knee_mv(i) - knee_mv(i - 1)) * 16;
               rise = knee_charge(i) - knee_charge(i - 1);
               result = knee_charge(i - 1) + (off * rise) / span;
               found = 1'b1;
            end
         end
      end
      return 14'(result);
   endfunction

   // Accumulates one sample; a completed group yields one expected reading.
   task automatic absorb_sample(input logic [23:0] word);
      int unsigned mv_avg, meas;
      reading_type r;
      code_acc = code_acc + word[11:0];
      mv_acc = mv_acc + word[23:12];
      if (samples_in + 1 < GROUP_SIZE) begin
         samples_in = samples_in + 1'b1;
      end else begin
         r.raw_average = 12'(code_acc / GROUP_SIZE);
         mv_avg = mv_acc / GROUP_SIZE;
         meas = (mv_avg * cfg_ratio) >> 8;
         if (meas > FILT_MAX) meas = FILT_MAX;
         if (filt_q4 <= cfg_seed_thr * 16)
            filt_q4 = 18'(meas);
         else
            filt_q4 = 18'((3 * filt_q4 + meas) >> 2);
         r.battery_mv = filt_q4[17:4];
         r.charge_hundredths = charge_of(filt_q4);
         r.is_charging = (filt_q4 > cfg_charge_thr * 16);
         code_acc = '0;
         mv_acc = '0;
         samples_in = '0;
         readings_due.push_back(r);
      end
   endtask

   task automatic check_field(input string label, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
      end
   endtask

   // Sample driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) absorb_sample(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(0, 11);
               req_tvalid <= 1'b0;
            end else begin
               req_tdata <= pending_samples.pop_front();
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // Reading monitor with its own back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (readings_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected reading, expected none, got tdata %h tuser %b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               front_reading = readings_due.pop_front();
               check_field("raw_average", front_reading.raw_average, rsp_tdata[11:0]);
               check_field("battery_mv", front_reading.battery_mv, rsp_tdata[25:12]);
               check_field("charge_hundredths", front_reading.charge_hundredths,
                           rsp_tdata[39:26]);
               check_field("is_charging", front_reading.is_charging, rsp_tuser);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_stall = $urandom_range(0, 11);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DIVIDER_RATIO: cfg_ratio = value;
         CSR_CHARGE_THR:    cfg_charge_thr = value[13:0];
         CSR_SEED_THR:      cfg_seed_thr = value[13:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [15:0] ratio, input logic [13:0] charge_thr,
                            input logic [13:0] seed_thr);
      write_reg(CSR_DIVIDER_RATIO, ratio);
      write_reg(CSR_CHARGE_THR, {2'b00, charge_thr});
      write_reg(CSR_SEED_THR, {2'b00, seed_thr});
   endtask

   // Waits for the gauge to drain, then for any group-end sequence to settle.
   task automatic wait_idle();
      while (pending_samples.size() != 0 || req_tvalid || readings_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One group of samples around the converter voltage that a target battery
   // voltage gives at the current divider ratio.
   task automatic queue_group(input int unsigned target_mv, input int spread);
      int base, s;
      logic [11:0] code;
      base = int'((target_mv * 4096) / cfg_ratio);
      if (base > 4095) base = 4095;
      repeat (GROUP_SIZE) begin
         s = base + int'($urandom_range(0, 2 * spread)) - spread;
         if (s < 0) s = 0;
         if (s > 4095) s = 4095;
         code = $urandom_range(0, 1) ? 12'(s) : 12'($urandom);
         pending_samples.push_back({12'(s), code});
      end
   endtask

   task automatic run_phase(input int n_items, input bit at_knees);
      int made, burst;
      int unsigned target;
      made = 0;
      @(negedge clock);
      while (made < n_items) begin
         if ($urandom_range(0, 99) < 15) begin
            // Noise: random fields in runs of random length that can break the group alignment.
            burst = $urandom_range(1, GROUP_SIZE);
            repeat (burst) pending_samples.push_back(24'($urandom));
            made += burst;
         end else begin
            if (at_knees)
               target = knee_mv($urandom_range(0, KNEES - 1)) + $urandom_range(0, 4) - 2;
            else
               target = $urandom_range(3150, 4350);
            queue_group(target, at_knees ? 0 : 6);
            made += GROUP_SIZE;
         end
      end
      wait_idle();
   endtask

   initial begin
      cfg_ratio = RATIO_RESET;
      cfg_charge_thr = CHARGE_RESET;
      cfg_seed_thr = SEED_RESET;
      code_acc = '0;
      mv_acc = '0;
      samples_in = '0;
      filt_q4 = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A group at the bottom of every field seeds the filter at zero, so a
      // group at the top seeds it again at full charge with the flag set.
      repeat (GROUP_SIZE) pending_samples.push_back(24'h000000);
      repeat (GROUP_SIZE) pending_samples.push_back(24'hFFFFFF);
      wait_idle();

      configure(16'd8192, 14'd4100, 14'd100);
      hold_ask <= hold_ask + 1;
      run_phase(260, 1'b0);

      configure(16'd65535, 14'd16383, 14'd0);
      run_phase(260, 1'b0);

      configure(16'd4096, 14'd0, 14'd16383);
      run_phase(260, 1'b0);

      // With a ratio of two the Q4 voltage lands on or next to the curve knees.
      configure(16'd8192, 14'($urandom_range(3300, 4200)), 14'd16383);
      run_phase(260, 1'b1);

      write_reg(CSR_UNMAPPED, 16'($urandom));
      configure(16'($urandom_range(4096, 65535)), 14'($urandom_range(0, 16383)),
                14'($urandom_range(0, 16383)));
      run_phase(260, 1'b0);

      idling_on = 1'b0;
      configure(16'($urandom_range(4096, 65535)), 14'($urandom_range(3300, 4300)),
                14'($urandom_range(0, 400)));
      run_phase(260, 1'b0);
      idling_on = 1'b1;

      configure(16'($urandom_range(6000, 12000)), 14'd4150, 14'd200);
      run_phase(130, 1'b0);

      idling_on = 1'b0;
      run_phase(130, 1'b0);

      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[filelist.f]
sv/bvg_pkg.sv
sv/bvg_accum.sv
sv/bvg_smul.sv
sv/bvg_sdiv.sv
sv/battery_voltage_gauge.sv
sim/testbench.sv
